// ===== sv/slf_pkg.sv =====
// types and constants for the session lifecycle machine
package slf_pkg;

	localparam int TIME_BITS      = 48;
	localparam int TRANSPORT_BITS = 32;
	localparam int PLAYER_BITS    = 64;
	localparam int TIMEOUT_BITS   = 32;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [TIMEOUT_BITS-1:0] DEFAULT_AUTH_TIMEOUT      = 32'd10000;
	localparam logic [TIMEOUT_BITS-1:0] DEFAULT_HEARTBEAT_TIMEOUT = 32'd30000;

	typedef enum logic [2:0] {
		ST_CREATED        = 3'd0,
		ST_AUTHENTICATING = 3'd1,
		ST_AUTHENTICATED  = 3'd2,
		ST_ONLINE         = 3'd3,
		ST_HB_TIMEOUT     = 3'd4,
		ST_RECONNECTING   = 3'd5,
		ST_CLOSING        = 3'd6,
		ST_CLOSED         = 3'd7
	} state_t;

	typedef enum logic [3:0] {
		EV_CREATE     = 4'd0,
		EV_START_AUTH = 4'd1,
		EV_AUTHED     = 4'd2,
		EV_ONLINE     = 4'd3,
		EV_HEARTBEAT  = 4'd4,
		EV_AUTH_CHECK = 4'd5,
		EV_HB_CHECK   = 4'd6,
		EV_CONN_CLOSE = 4'd7,
		EV_RECONNECT  = 4'd8,
		EV_CLOSE      = 4'd9,
		EV_BIND       = 4'd10,
		EV_DETACH     = 4'd11
	} event_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_AUTH_TIMEOUT      = 2'd0,
		CFG_HEARTBEAT_TIMEOUT = 2'd1
	} cfg_reg_t;

	localparam logic [7:0] RSN_NONE         = 8'd0;
	localparam logic [7:0] RSN_AUTH_TIMEOUT = 8'd1;
	localparam logic [7:0] RSN_HB_TIMEOUT   = 8'd2;

	typedef struct packed {
		logic [3:0]                mode;
		logic [TIME_BITS-1:0]      now;
		logic [PLAYER_BITS-1:0]    player_id;
		logic [TRANSPORT_BITS-1:0] transport_id;
		logic [7:0]                reason_code;
	} in_req_t;

	typedef struct packed {
		logic                   accepted;
		logic [2:0]             session_state;
		logic                   has_transport;
		logic [7:0]             close_code;
		logic [PLAYER_BITS-1:0] player_out;
	} out_rsp_t;

endpackage

// ===== sv/session_lifecycle_fsm.sv =====
// Session lifecycle machine: one request per event, one response per request.
// Each accepted request is held in an input register and, once the response register
// is free or being read, resolved against the session state (compare of the auth
// deadline, modulo difference of the heartbeat time, one saturating add for a new
// deadline), which updates the state and loads the response register in the same cycle.
// Throughput is one request per clock while responses are taken. A new request is taken
// while a response waits, as long as the input register frees up in that cycle. The user
// must write timeout registers through the configuration port only while no request is in
// flight; the block does not enforce this. A value of zero selects the built-in default.
module session_lifecycle_fsm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  slf_pkg::in_req_t                       in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output slf_pkg::out_rsp_t                      out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [slf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [slf_pkg::TIMEOUT_BITS-1:0]       cfg_data
);
	import slf_pkg::*;

	logic                      valid_s1;
	in_req_t                   req_s1;
	logic                      fire_s1;
	logic                      out_valid_q;
	out_rsp_t                  out_q;

	logic [TIMEOUT_BITS-1:0]   auth_timeout_q;
	logic [TIMEOUT_BITS-1:0]   hb_timeout_q;

	state_t                    state_q;
	logic [TIME_BITS-1:0]      deadline_q;
	logic [TIME_BITS-1:0]      last_hb_q;
	logic [TRANSPORT_BITS-1:0] transport_q;
	logic [PLAYER_BITS-1:0]    player_q;
	logic [7:0]                reason_q;

	state_t                    state_d;
	logic                      ok;
	logic [TIME_BITS-1:0]      deadline_d;
	logic [TIME_BITS-1:0]      last_hb_d;
	logic [TRANSPORT_BITS-1:0] transport_d;
	logic [PLAYER_BITS-1:0]    player_d;
	logic [7:0]                reason_d;
	out_rsp_t                  rsp_d;

	logic [TIMEOUT_BITS-1:0]   eff_auth;
	logic [TIMEOUT_BITS-1:0]   eff_hb;
	logic [TIME_BITS:0]        deadline_sum;
	logic [TIME_BITS-1:0]      new_deadline;
	logic [TIME_BITS-1:0]      hb_diff;
	logic                      auth_expired;
	logic                      hb_expired;

	assign fire_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auth_timeout_q <= DEFAULT_AUTH_TIMEOUT;
			hb_timeout_q   <= DEFAULT_HEARTBEAT_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_AUTH_TIMEOUT:      auth_timeout_q <= cfg_data;
				CFG_HEARTBEAT_TIMEOUT: hb_timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// timing arithmetic
	always_comb begin
		eff_auth     = (auth_timeout_q != '0) ? auth_timeout_q : DEFAULT_AUTH_TIMEOUT;
		eff_hb       = (hb_timeout_q != '0) ? hb_timeout_q : DEFAULT_HEARTBEAT_TIMEOUT;
		deadline_sum = {1'b0, req_s1.now} + {{(TIME_BITS + 1 - TIMEOUT_BITS){1'b0}}, eff_auth};
		new_deadline = deadline_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
		                                       : deadline_sum[TIME_BITS-1:0];
		hb_diff      = req_s1.now - last_hb_q;
		auth_expired = req_s1.now >= deadline_q;
		hb_expired   = hb_diff >= {{(TIME_BITS - TIMEOUT_BITS){1'b0}}, eff_hb};
	end

	// next state
	always_comb begin
		state_d = state_q;
		ok      = 1'b0;
		unique case (req_s1.mode)
			EV_CREATE: begin
				state_d = ST_CREATED;
				ok      = 1'b1;
			end
			EV_START_AUTH: begin
				if (state_q == ST_CREATED) begin
					state_d = ST_AUTHENTICATING;
					ok      = 1'b1;
				end
			end
			EV_AUTHED: begin
				if (state_q == ST_AUTHENTICATING || state_q == ST_CREATED) begin
					state_d = ST_AUTHENTICATED;
					ok      = 1'b1;
				end
			end
			EV_ONLINE: begin
				if (state_q == ST_AUTHENTICATED || state_q == ST_RECONNECTING ||
				    state_q == ST_HB_TIMEOUT) begin
					state_d = ST_ONLINE;
					ok      = 1'b1;
				end
			end
			EV_HEARTBEAT: begin
				if (state_q == ST_ONLINE || state_q == ST_HB_TIMEOUT) begin
					state_d = ST_ONLINE;
					ok      = 1'b1;
				end
			end
			EV_AUTH_CHECK: begin
				if ((state_q == ST_AUTHENTICATING || state_q == ST_CREATED) && auth_expired) begin
					state_d = ST_CLOSED;
					ok      = 1'b1;
				end
			end
			EV_HB_CHECK: begin
				if (state_q == ST_ONLINE && hb_expired) begin
					state_d = ST_HB_TIMEOUT;
					ok      = 1'b1;
				end
			end
			EV_CONN_CLOSE: begin
				if (state_q != ST_CLOSING && state_q != ST_CLOSED) begin
					state_d = ST_CLOSING;
					ok      = 1'b1;
				end
			end
			EV_RECONNECT: begin
				if (state_q == ST_CLOSING) begin
					state_d = ST_RECONNECTING;
					ok      = 1'b1;
				end
			end
			EV_CLOSE: begin
				if (state_q != ST_CLOSED) begin
					state_d = ST_CLOSED;
					ok      = 1'b1;
				end
			end
			EV_BIND: begin
				ok = (state_q != ST_CLOSED) && (transport_q != req_s1.transport_id);
			end
			EV_DETACH: begin
				ok = transport_q != '0;
			end
			default: ;
		endcase
	end

	// data updates and response
	always_comb begin
		deadline_d  = deadline_q;
		last_hb_d   = last_hb_q;
		transport_d = transport_q;
		player_d    = player_q;
		reason_d    = reason_q;
		if (ok) begin
			unique case (req_s1.mode)
				EV_CREATE: begin
					transport_d = req_s1.transport_id;
					last_hb_d   = req_s1.now;
					player_d    = '0;
					reason_d    = RSN_NONE;
					deadline_d  = new_deadline;
				end
				EV_START_AUTH: deadline_d = new_deadline;
				EV_AUTHED: begin
					player_d  = req_s1.player_id;
					last_hb_d = req_s1.now;
				end
				EV_ONLINE, EV_HEARTBEAT: last_hb_d = req_s1.now;
				EV_AUTH_CHECK: reason_d = RSN_AUTH_TIMEOUT;
				EV_HB_CHECK:   reason_d = RSN_HB_TIMEOUT;
				EV_CONN_CLOSE, EV_CLOSE: reason_d = req_s1.reason_code;
				EV_RECONNECT:  reason_d = RSN_NONE;
				EV_BIND:       transport_d = req_s1.transport_id;
				EV_DETACH:     transport_d = '0;
				default: ;
			endcase
		end
		rsp_d.accepted      = ok;
		rsp_d.session_state = state_d;
		rsp_d.has_transport = transport_d != '0;
		rsp_d.close_code    = reason_d;
		rsp_d.player_out    = player_d;
	end

	// session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CREATED;
			deadline_q  <= {{(TIME_BITS - TIMEOUT_BITS){1'b0}}, DEFAULT_AUTH_TIMEOUT};
			last_hb_q   <= '0;
			transport_q <= '0;
			player_q    <= '0;
			reason_q    <= RSN_NONE;
		end else if (fire_s1) begin
			state_q     <= state_d;
			deadline_q  <= deadline_d;
			last_hb_q   <= last_hb_d;
			transport_q <= transport_d;
			player_q    <= player_d;
			reason_q    <= reason_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	// a rejected request leaves the session untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !ok) |=> (state_q == $past(state_q) && reason_q == $past(reason_q) &&
		                      transport_q == $past(transport_q)))
		else $error("rejected request changed session state");

	// a pending response reflects the current session
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.session_state == state_q &&
		                 out_q.has_transport == (transport_q != '0) &&
		                 out_q.close_code == reason_q))
		else $error("response out of step with session state");

	// accepted auth check closes with the auth timeout code
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && ok && req_s1.mode == EV_AUTH_CHECK) |=>
		(state_q == ST_CLOSED && reason_q == RSN_AUTH_TIMEOUT))
		else $error("auth check did not close session");

	// a held request is not lost
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire_s1) |=> valid_s1)
		else $error("input register dropped a request");
`endif

endmodule

// ===== tb/sv/tb_session_lifecycle_fsm.sv =====
// testbench for session_lifecycle_fsm: directed and random event requests checked against a scoreboard
module tb_session_lifecycle_fsm;
	import slf_pkg::*;

	localparam logic [3:0]           EV_SPARE_LO = 4'd12;
	localparam logic [3:0]           EV_SPARE_HI = 4'd15;
	localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
	localparam int                   PHASE_ITEMS = 120;

	class session_scoreboard;
		state_t                    st;
		logic [TIME_BITS-1:0]      auth_deadline;
		logic [TIME_BITS-1:0]      last_hb;
		logic [TRANSPORT_BITS-1:0] bound_tid;
		logic [PLAYER_BITS-1:0]    player;
		logic [7:0]                reason;
		logic [TIMEOUT_BITS-1:0]   auth_to;
		logic [TIMEOUT_BITS-1:0]   hb_to;
		out_rsp_t                  status_q[$];
		int                        fail_count;

		function new();
			st            = ST_CREATED;
			auth_deadline = TIME_BITS'(DEFAULT_AUTH_TIMEOUT);
			last_hb       = '0;
			bound_tid     = '0;
			player        = '0;
			reason        = RSN_NONE;
			auth_to       = DEFAULT_AUTH_TIMEOUT;
			hb_to         = DEFAULT_HEARTBEAT_TIMEOUT;
			fail_count    = 0;
		endfunction

		function logic [TIMEOUT_BITS-1:0] hb_limit();
			return (hb_to != '0) ? hb_to : DEFAULT_HEARTBEAT_TIMEOUT;
		endfunction

		// saturating deadline
		function logic [TIME_BITS-1:0] deadline_after(logic [TIME_BITS-1:0] t);
			logic [TIME_BITS:0]      sum;
			logic [TIMEOUT_BITS-1:0] add;
			add = (auth_to != '0) ? auth_to : DEFAULT_AUTH_TIMEOUT;
			sum = {1'b0, t} + (TIME_BITS + 1)'(add);
			return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
		endfunction

		function void set_timeout(cfg_reg_t idx, logic [TIMEOUT_BITS-1:0] v);
			case (idx)
				CFG_AUTH_TIMEOUT:      auth_to = v;
				CFG_HEARTBEAT_TIMEOUT: hb_to = v;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return status_q.size();
		endfunction

		function void note_event(in_req_t r);
			logic                 ok;
			logic [TIME_BITS-1:0] since_hb;
			out_rsp_t             want;
			ok = 1'b0;
			since_hb = r.now - last_hb;
			case (r.mode)
				EV_CREATE: begin
					st = ST_CREATED;
					bound_tid = r.transport_id;
					last_hb = r.now;
					player = '0;
					reason = RSN_NONE;
					auth_deadline = deadline_after(r.now);
					ok = 1'b1;
				end
				EV_START_AUTH: if (st == ST_CREATED) begin
					st = ST_AUTHENTICATING;
					auth_deadline = deadline_after(r.now);
					ok = 1'b1;
				end
				EV_AUTHED: if (st == ST_AUTHENTICATING || st == ST_CREATED) begin
					player = r.player_id;
					last_hb = r.now;
					st = ST_AUTHENTICATED;
					ok = 1'b1;
				end
				EV_ONLINE: begin
					if (st == ST_AUTHENTICATED || st == ST_RECONNECTING || st == ST_HB_TIMEOUT) begin
						last_hb = r.now;
						st = ST_ONLINE;
						ok = 1'b1;
					end
				end
				EV_HEARTBEAT: if (st == ST_ONLINE || st == ST_HB_TIMEOUT) begin
					st = ST_ONLINE;
					last_hb = r.now;
					ok = 1'b1;
				end
				EV_AUTH_CHECK: begin
					if ((st == ST_AUTHENTICATING || st == ST_CREATED) && r.now >= auth_deadline) begin
						reason = RSN_AUTH_TIMEOUT;
						st = ST_CLOSED;
						ok = 1'b1;
					end
				end
				EV_HB_CHECK: if (st == ST_ONLINE && since_hb >= TIME_BITS'(hb_limit())) begin
					reason = RSN_HB_TIMEOUT;
					st = ST_HB_TIMEOUT;
					ok = 1'b1;
				end
				EV_CONN_CLOSE: if (st != ST_CLOSING && st != ST_CLOSED) begin
					reason = r.reason_code;
					st = ST_CLOSING;
					ok = 1'b1;
				end
				EV_RECONNECT: if (st == ST_CLOSING) begin
					reason = RSN_NONE;
					st = ST_RECONNECTING;
					ok = 1'b1;
				end
				EV_CLOSE: if (st != ST_CLOSED) begin
					reason = r.reason_code;
					st = ST_CLOSED;
					ok = 1'b1;
				end
				EV_BIND: if (st != ST_CLOSED && bound_tid != r.transport_id) begin
					bound_tid = r.transport_id;
					ok = 1'b1;
				end
				EV_DETACH: if (bound_tid != '0) begin
					bound_tid = '0;
					ok = 1'b1;
				end
				default: ;
			endcase
			want.accepted      = ok;
			want.session_state = st;
			want.has_transport = (bound_tid != '0);
			want.close_code    = reason;
			want.player_out    = player;
			status_q.push_back(want);
		endfunction

		task report(string what);
			fail_count++;
			if (fail_count <= 100)
				$display("mismatch at %0t: %s", $realtime, what);
		endtask

		task check_status(out_rsp_t got);
			out_rsp_t want;
			if (status_q.size() == 0) begin
				report($sformatf("response with no request outstanding: %h", got));
				return;
			end
			want = status_q.pop_front();
			if (got.accepted !== want.accepted)
				report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
			if (got.session_state !== want.session_state)
				report($sformatf("session_state %0d, want %0d", got.session_state,
					want.session_state));
			if (got.has_transport !== want.has_transport)
				report($sformatf("has_transport %b, want %b", got.has_transport,
					want.has_transport));
			if (got.close_code !== want.close_code)
				report($sformatf("close_code %0d, want %0d", got.close_code, want.close_code));
			if (got.player_out !== want.player_out)
				report($sformatf("player_out %h, want %h", got.player_out, want.player_out));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	in_req_t                  in_data;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	out_rsp_t                 out_data;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [TIMEOUT_BITS-1:0]  cfg_data;

	session_scoreboard        sb;
	int                       gap_pct = 0;
	int                       stall_pct = 0;
	logic [TIME_BITS-1:0]     clock_ms;

	session_lifecycle_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_status(out_data);
			if (in_valid && in_ready)
				sb.note_event(in_data);
			if (cfg_valid && cfg_ready)
				sb.set_timeout(cfg_reg_t'(cfg_index), cfg_data);
		end
	end

	function automatic in_req_t make_event(logic [3:0] m, logic [TIME_BITS-1:0] t,
			logic [PLAYER_BITS-1:0] pid, logic [TRANSPORT_BITS-1:0] tid, logic [7:0] rsn);
		in_req_t r;
		r.mode         = m;
		r.now          = t;
		r.player_id    = pid;
		r.transport_id = tid;
		r.reason_code  = rsn;
		return r;
	endfunction

	// mostly events that make sense in the current state, some noise
	function automatic in_req_t next_session_event();
		in_req_t r;
		event_t  choices[$];
		int      pick;
		pick = $urandom_range(99);
		case (sb.st)
			ST_CREATED:        choices = '{EV_START_AUTH, EV_AUTHED, EV_AUTH_CHECK, EV_BIND};
			ST_AUTHENTICATING: choices = '{EV_AUTHED, EV_AUTH_CHECK, EV_AUTH_CHECK};
			ST_AUTHENTICATED:  choices = '{EV_ONLINE, EV_ONLINE, EV_BIND, EV_DETACH};
			ST_ONLINE:         choices = '{EV_HEARTBEAT, EV_HB_CHECK, EV_HB_CHECK, EV_CONN_CLOSE};
			ST_HB_TIMEOUT:     choices = '{EV_ONLINE, EV_HEARTBEAT, EV_CONN_CLOSE};
			ST_RECONNECTING:   choices = '{EV_ONLINE, EV_ONLINE, EV_CLOSE};
			ST_CLOSING:        choices = '{EV_RECONNECT, EV_RECONNECT, EV_CLOSE};
			default:           choices = '{EV_CREATE, EV_CREATE, EV_CREATE, EV_DETACH};
		endcase
		if (pick < 6)
			r.mode = 4'($urandom_range(15));
		else if (pick < 14)
			r.mode = 4'($urandom_range(EV_CONN_CLOSE, EV_DETACH));
		else
			r.mode = choices[$urandom_range(choices.size() - 1)];

		clock_ms = clock_ms + TIME_BITS'($urandom_range(2000));
		r.now = clock_ms;
		if ($urandom_range(19) == 0)
			r.now = TIME_BITS'({$urandom(), $urandom()});
		else if (r.mode == EV_AUTH_CHECK && $urandom_range(3) != 0)
			r.now = sb.auth_deadline + TIME_BITS'($urandom_range(2)) - 1'b1;
		else if (r.mode == EV_HB_CHECK && $urandom_range(3) != 0)
			r.now = sb.last_hb + TIME_BITS'(sb.hb_limit()) + TIME_BITS'($urandom_range(2)) - 1'b1;
		clock_ms = r.now;

		case ($urandom_range(5))
			0:       r.player_id = '0;
			1:       r.player_id = '1;
			default: r.player_id = {$urandom(), $urandom()};
		endcase
		case ($urandom_range(3))
			0:       r.transport_id = '0;
			1:       r.transport_id = sb.bound_tid;
			default: r.transport_id = TRANSPORT_BITS'($urandom());
		endcase
		r.reason_code = 8'($urandom_range(255));
		return r;
	endfunction

	task automatic send_event(in_req_t r);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_requests();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [TIMEOUT_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_timeouts(logic [TIMEOUT_BITS-1:0] auth_v,
			logic [TIMEOUT_BITS-1:0] hb_v);
		drain_requests();
		write_reg(CFG_AUTH_TIMEOUT, auth_v);
		write_reg(CFG_HEARTBEAT_TIMEOUT, hb_v);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_directed();
		send_event(make_event(EV_AUTH_CHECK, 48'd9999, '0, '0, '0));
		send_event(make_event(EV_AUTH_CHECK, 48'd10000, '0, '0, '0));
		send_event(make_event(EV_BIND, 48'd10001, '0, 32'd7, '0));
		send_event(make_event(EV_DETACH, 48'd10002, '0, '0, '0));
		send_event(make_event(EV_SPARE_LO, 48'd10003, '1, '1, '1));
		send_event(make_event(EV_SPARE_HI, 48'd10004, '1, '1, '1));
		// deadline pinned at the top of the time range
		send_event(make_event(EV_CREATE, TIME_MAX - 48'd5000, '0, '1, '0));
		send_event(make_event(EV_AUTH_CHECK, TIME_MAX - 48'd1, '0, '0, '0));
		send_event(make_event(EV_AUTH_CHECK, TIME_MAX, '0, '0, '0));
		send_event(make_event(EV_CREATE, 48'd100, '0, '0, '0));
		send_event(make_event(EV_START_AUTH, 48'd200, '0, '0, '0));
		send_event(make_event(EV_START_AUTH, 48'd250, '0, '0, '0));
		send_event(make_event(EV_AUTHED, 48'd300, '1, '0, '0));
		send_event(make_event(EV_ONLINE, 48'd1000, '0, '0, '0));
		send_event(make_event(EV_HEARTBEAT, 48'd2000, '0, '0, '0));
		send_event(make_event(EV_HB_CHECK, 48'd31999, '0, '0, '0));
		send_event(make_event(EV_HB_CHECK, 48'd32000, '0, '0, '0));
		// heartbeat gap across the time wrap
		send_event(make_event(EV_HEARTBEAT, TIME_MAX, '0, '0, '0));
		send_event(make_event(EV_HB_CHECK, 48'd29998, '0, '0, '0));
		send_event(make_event(EV_HB_CHECK, 48'd29999, '0, '0, '0));
		send_event(make_event(EV_ONLINE, 48'd30000, '0, '0, '0));
		send_event(make_event(EV_BIND, 48'd30001, '0, 32'd5, '0));
		send_event(make_event(EV_BIND, 48'd30002, '0, 32'd5, '0));
		send_event(make_event(EV_DETACH, 48'd30003, '0, '0, '0));
		send_event(make_event(EV_CONN_CLOSE, 48'd30004, '0, '0, 8'hff));
		send_event(make_event(EV_RECONNECT, 48'd30005, '0, '0, '0));
		send_event(make_event(EV_CLOSE, 48'd30006, '0, '0, 8'ha5));
		send_event(make_event(EV_RECONNECT, 48'd30007, '0, '0, '0));
	endtask

	task automatic run_phase(int gap, int stall, logic [TIMEOUT_BITS-1:0] auth_v,
			logic [TIMEOUT_BITS-1:0] hb_v);
		set_timeouts(auth_v, hb_v);
		gap_pct   = gap;
		stall_pct = stall;
		repeat (PHASE_ITEMS)
			send_event(next_session_event());
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_AUTH_TIMEOUT;
		cfg_data  = '0;
		clock_ms  = 48'd40000;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		run_phase(0, 0, 32'd1, 32'hffff_ffff);
		run_phase(48, 0, 32'hffff_ffff, 32'd1);
		run_phase(0, 48, 32'd0, 32'd0);
		run_phase(34, 34, 32'($urandom_range(1, 50000)), 32'($urandom_range(1, 50000)));

		drain_requests();
		repeat (10) @(negedge clk);
		if (sb.fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
